[rtl/cpe_pkg.sv]
package cpe_pkg;

    localparam int unsigned MAX_PAYLOAD    = 256;
    localparam int unsigned LEN_W          = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned FRAME_OVERHEAD = 16;
    localparam int unsigned STEP_W         = $clog2(FRAME_OVERHEAD);
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned Q_AW           = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic FUNC_HEADER  = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NO_FRAME = 2'd3;

    localparam logic [1:0] REG_MAGIC_FIRST     = 2'd0;
    localparam logic [1:0] REG_MAGIC_SECOND    = 2'd1;
    localparam logic [1:0] REG_FORMAT_VERSION  = 2'd2;
    localparam logic [1:0] REG_FRAME_CAPACITY  = 2'd3;

    // header byte offsets
    localparam logic [STEP_W-1:0] OFS_MAGIC0   = STEP_W'(0);
    localparam logic [STEP_W-1:0] OFS_MAGIC1   = STEP_W'(1);
    localparam logic [STEP_W-1:0] OFS_VERSION  = STEP_W'(2);
    localparam logic [STEP_W-1:0] OFS_TYPE     = STEP_W'(3);
    localparam logic [STEP_W-1:0] OFS_FLAGS    = STEP_W'(4);
    localparam logic [STEP_W-1:0] OFS_RSVD     = STEP_W'(5);
    localparam logic [STEP_W-1:0] OFS_SEQ_LO   = STEP_W'(6);
    localparam logic [STEP_W-1:0] OFS_SEQ_HI   = STEP_W'(7);
    localparam logic [STEP_W-1:0] OFS_TS_0     = STEP_W'(8);
    localparam logic [STEP_W-1:0] OFS_TS_1     = STEP_W'(9);
    localparam logic [STEP_W-1:0] OFS_TS_2     = STEP_W'(10);
    localparam logic [STEP_W-1:0] OFS_TS_3     = STEP_W'(11);
    localparam logic [STEP_W-1:0] OFS_LEN_LO   = STEP_W'(12);
    localparam logic [STEP_W-1:0] OFS_LEN_HI   = STEP_W'(13);
    localparam logic [STEP_W-1:0] OFS_CRC_LO   = STEP_W'(14);
    localparam logic [STEP_W-1:0] OFS_CRC_HI   = STEP_W'(15);

    // payload command steps
    localparam logic [STEP_W-1:0] PAY_DATA     = STEP_W'(0);
    localparam logic [STEP_W-1:0] PAY_CRC_LO   = STEP_W'(1);
    localparam logic [STEP_W-1:0] PAY_CRC_HI   = STEP_W'(2);

    typedef enum logic [1:0] {
        CMD_HDR,
        CMD_PAY,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [1:0]       status;
        logic [7:0]       msg_type;
        logic [7:0]       flags;
        logic [15:0]      seq;
        logic [31:0]      ts;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        logic             close;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  magic_first;
        logic [7:0]  magic_second;
        logic [7:0]  format_version;
        logic [15:0] frame_capacity;
    } cfg_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[rtl/crc16_framed_packet_encoder.sv]
// Frame builder with a CRC-16/CCITT-FALSE trailer. A header transaction
// (s_tuser 0) is checked against the payload limit and the output capacity and
// then expands into 14 header bytes, plus the two CRC bytes when the payload is
// empty; each payload transaction (s_tuser 1) gives one byte, and the byte that
// closes the frame is followed by the CRC low and high bytes. Errors give a
// single result with tlast set and the status in m_tuser. The front end takes
// one input transaction per cycle, while the queue is not full, into a
// four-entry command queue; the back end sequencer emits one result byte per
// cycle while m_tready holds. Each result is registered in the command queue,
// then in the output register. The user must make configuration writes only
// while the block is idle; the block itself does not enforce it.
module crc16_framed_packet_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // msg_type, flag_bits, sequence_number,
                                   // ts_ms, pay_len, payload_byte
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte, frame_length
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cpe_pkg::cfg_t cfg_reg;
    cpe_pkg::cmd_t push_cmd, head;
    logic          push, pop, q_empty, q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_first    <= 8'h00;
            cfg_reg.magic_second   <= 8'h00;
            cfg_reg.format_version <= 8'h00;
            cfg_reg.frame_capacity <= 16'hFFFF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cpe_pkg::REG_MAGIC_FIRST:    cfg_reg.magic_first    <= cfg_wdata[7:0];
                cpe_pkg::REG_MAGIC_SECOND:   cfg_reg.magic_second   <= cfg_wdata[7:0];
                cpe_pkg::REG_FORMAT_VERSION: cfg_reg.format_version <= cfg_wdata[7:0];
                cpe_pkg::REG_FRAME_CAPACITY: cfg_reg.frame_capacity <= cfg_wdata;
                default: ;
            endcase
        end
    end

    cpe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    cpe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    cpe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("command pushed into full queue");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty)
        else $error("command popped from empty queue");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != cpe_pkg::ST_OK)) |-> (m_tlast && (m_tdata[7:0] == 8'h00)))
        else $error("error result not a single last transaction");

    a_length_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[23:8] == 16'd0))
        else $error("frame length on a non-final transaction");
`endif

endmodule

[rtl/cpe_front.sv]
module cpe_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cpe_pkg::cfg_t        cfg,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [87:0]          s_tdata,  // msg_type, flag_bits, sequence_number,
                                           // ts_ms, pay_len, payload_byte
    input  logic                 s_tuser,  // func
    input  logic                 q_full,
    output logic                 push,
    output cpe_pkg::cmd_t        cmd
);

    logic                        active_reg, active_next;
    logic [cpe_pkg::LEN_W-1:0]   remaining_reg, remaining_next;
    logic [15:0]                 len_in;
    logic [16:0]                 need_total;

    assign s_tready   = !q_full;
    assign push       = s_tvalid && !q_full;
    assign len_in     = s_tdata[79:64];
    assign need_total = {1'b0, len_in} + 17'(cpe_pkg::FRAME_OVERHEAD);

    always_comb begin
        cmd.kind       = cpe_pkg::CMD_ERR;
        cmd.status     = cpe_pkg::ST_OK;
        cmd.msg_type   = s_tdata[7:0];
        cmd.flags      = s_tdata[15:8];
        cmd.seq        = s_tdata[31:16];
        cmd.ts         = s_tdata[63:32];
        cmd.len        = len_in[cpe_pkg::LEN_W-1:0];
        cmd.data       = s_tdata[87:80];
        cmd.close      = 1'b0;
        active_next    = active_reg;
        remaining_next = remaining_reg;
        if (s_tuser == cpe_pkg::FUNC_HEADER) begin
            active_next    = 1'b0;
            remaining_next = '0;
            priority if (len_in > 16'(cpe_pkg::MAX_PAYLOAD)) begin
                cmd.status = cpe_pkg::ST_BAD_LEN;
            end else if ({1'b0, cfg.frame_capacity} < need_total) begin
                cmd.status = cpe_pkg::ST_OVERFLOW;
            end else begin
                cmd.kind       = cpe_pkg::CMD_HDR;
                active_next    = (len_in != 16'd0);
                remaining_next = len_in[cpe_pkg::LEN_W-1:0];
            end
        end else if (!active_reg) begin
            cmd.status = cpe_pkg::ST_NO_FRAME;
        end else begin
            cmd.kind       = cpe_pkg::CMD_PAY;
            cmd.close      = (remaining_reg == cpe_pkg::LEN_W'(1));
            remaining_next = remaining_reg - cpe_pkg::LEN_W'(1);
            active_next    = !cmd.close;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            remaining_reg <= '0;
        end else if (push) begin
            active_reg    <= active_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

[rtl/cpe_queue.sv]
module cpe_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cpe_pkg::cmd_t push_cmd,
    input  logic          pop,
    output cpe_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    cpe_pkg::cmd_t            entry_reg [cpe_pkg::QUEUE_DEPTH];
    logic [cpe_pkg::Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cpe_pkg::Q_AW:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (cpe_pkg::Q_AW + 1)'(cpe_pkg::QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/cpe_back.sv]
module cpe_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  cpe_pkg::cfg_t cfg,
    input  cpe_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,  // out_byte, frame_length
    output logic          m_tlast,
    output logic [1:0]    m_tuser   // status
);

    logic [cpe_pkg::STEP_W-1:0] step_reg, step_next;
    logic [15:0]                crc_reg, crc_next;
    logic [15:0]                ftotal_reg, ftotal_next;
    logic                       valid_reg;
    logic [7:0]                 byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic [1:0]                 status_reg, status_next;
    logic [15:0]                flen_reg, flen_next;
    logic                       load, feed, finish;
    logic [15:0]                hdr_total;

    assign load      = !q_empty && (!valid_reg || m_tready);
    assign pop       = load && finish;
    assign hdr_total = 16'(cpe_pkg::FRAME_OVERHEAD) + 16'(head.len);

    always_comb begin
        byte_next   = 8'h00;
        last_next   = 1'b0;
        status_next = cpe_pkg::ST_OK;
        flen_next   = 16'd0;
        feed        = 1'b0;
        finish      = 1'b0;
        ftotal_next = ftotal_reg;
        crc_next    = crc_reg;
        unique case (head.kind)
            cpe_pkg::CMD_HDR: begin
                feed = (step_reg >= cpe_pkg::OFS_VERSION) && (step_reg <= cpe_pkg::OFS_LEN_HI);
                unique case (step_reg)
                    cpe_pkg::OFS_MAGIC0: begin
                        byte_next   = cfg.magic_first;
                        crc_next    = cpe_pkg::CRC_INIT;
                        ftotal_next = hdr_total;
                    end
                    cpe_pkg::OFS_MAGIC1:  byte_next = cfg.magic_second;
                    cpe_pkg::OFS_VERSION: byte_next = cfg.format_version;
                    cpe_pkg::OFS_TYPE:    byte_next = head.msg_type;
                    cpe_pkg::OFS_FLAGS:   byte_next = head.flags;
                    cpe_pkg::OFS_RSVD:    byte_next = 8'h00;
                    cpe_pkg::OFS_SEQ_LO:  byte_next = head.seq[7:0];
                    cpe_pkg::OFS_SEQ_HI:  byte_next = head.seq[15:8];
                    cpe_pkg::OFS_TS_0:    byte_next = head.ts[7:0];
                    cpe_pkg::OFS_TS_1:    byte_next = head.ts[15:8];
                    cpe_pkg::OFS_TS_2:    byte_next = head.ts[23:16];
                    cpe_pkg::OFS_TS_3:    byte_next = head.ts[31:24];
                    cpe_pkg::OFS_LEN_LO:  byte_next = head.len[7:0];
                    cpe_pkg::OFS_LEN_HI: begin
                        byte_next = 8'(head.len >> 8);
                        last_next = (head.len != '0);
                        finish    = (head.len != '0);
                    end
                    cpe_pkg::OFS_CRC_LO:  byte_next = crc_reg[7:0];
                    cpe_pkg::OFS_CRC_HI: begin
                        byte_next = crc_reg[15:8];
                        last_next = 1'b1;
                        flen_next = hdr_total;
                        finish    = 1'b1;
                    end
                    default: finish = 1'b1;
                endcase
            end
            cpe_pkg::CMD_PAY: begin
                unique case (step_reg)
                    cpe_pkg::PAY_DATA: begin
                        byte_next = head.data;
                        feed      = 1'b1;
                        last_next = !head.close;
                        finish    = !head.close;
                    end
                    cpe_pkg::PAY_CRC_LO: byte_next = crc_reg[7:0];
                    cpe_pkg::PAY_CRC_HI: begin
                        byte_next = crc_reg[15:8];
                        last_next = 1'b1;
                        flen_next = ftotal_reg;
                        finish    = 1'b1;
                    end
                    default: finish = 1'b1;
                endcase
            end
            cpe_pkg::CMD_ERR: begin
                last_next   = 1'b1;
                status_next = head.status;
                finish      = 1'b1;
            end
            default: finish = 1'b1;
        endcase
        if (feed) begin
            crc_next = cpe_pkg::crc_feed(crc_reg, byte_next);
        end
        step_next = finish ? '0 : step_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= '0;
            crc_reg    <= cpe_pkg::CRC_INIT;
            ftotal_reg <= 16'd0;
            valid_reg  <= 1'b0;
        end else begin
            if (load) begin
                step_reg   <= step_next;
                crc_reg    <= crc_next;
                ftotal_reg <= ftotal_next;
                valid_reg  <= 1'b1;
            end else if (m_tready) begin
                valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= byte_next;
            last_reg   <= last_next;
            status_reg <= status_next;
            flen_reg   <= flen_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {flen_reg, byte_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = status_reg;

endmodule
